@@ hdl/rlts_pkg.sv @@
// ----------------------------------------------------------------------------
// rlts_pkg
// Shared types and constants of the replicated log term store: operation and
// status codes, sequencer states and the request and result item structs.
// ----------------------------------------------------------------------------
package rlts_pkg;

   // default number of ring slots
   localparam int unsigned LOG_DEPTH_DEF = 1024;

   // operation codes carried by a request item
   typedef enum logic [2:0] {
      OP_APPEND      = 3'd0,
      OP_COMPACT     = 3'd1,
      OP_TERM_QUERY  = 3'd2,
      OP_COMMIT_TO   = 3'd3,
      OP_APPLY_SNAP  = 3'd4,
      OP_SNAP_QUERY  = 3'd5
   } op_type;

   // status codes carried by a result item
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_COMPACTED   = 3'd1,
      ST_UNAVAILABLE = 3'd2,
      ST_GAP         = 3'd3,
      ST_STALE       = 3'd4,
      ST_BEYOND      = 3'd5,
      ST_FULL        = 3'd6,
      ST_NO_ENTRY    = 3'd7
   } status_type;

   // where the result term comes from
   typedef enum logic [1:0] {
      TSRC_ZERO = 2'd0,
      TSRC_SNAP = 2'd1,
      TSRC_RING = 2'd2
   } tsrc_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DECODE = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] log_index;
      logic [63:0] entry_term;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] result_term;
      logic [63:0] result_index;
      logic [63:0] first_entry_index;
      logic [63:0] last_entry_index;
      logic [63:0] committed_index;
      logic [63:0] hard_term;
   } rsp_type;

endpackage

@@ hdl/replicated_log_term_store.sv @@
// ----------------------------------------------------------------------------
// replicated_log_term_store
// Term store of a consensus log: a ring of entry terms plus snapshot, commit
// and hard-term registers, one operation per item, one result per item.
// ----------------------------------------------------------------------------
// Each item passes two states: decode, which decodes it and accesses
// the single-port term ring, whose read data is registered, and finish,
// which commits the index state and hands the result to the output
// register. A new item is taken in the same cycle as the previous one finishes,
// and a result waiting in the output register does not hold up the next item
// until a second one is ready. LOG_DEPTH sets the number of ring slots; the
// ring is not cleared after reset, as only data read from held slots is used.
module replicated_log_term_store
   import rlts_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = LOG_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    done_valid;
   rsp_type done_data;

   rlts_engine #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_free   (out_free),
      .done_valid (done_valid),
      .done_data  (done_data)
   );

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (done_valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && out_free) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/rlts_term_ring.sv @@
// ----------------------------------------------------------------------------
// rlts_term_ring
// Single-port term memory with a registered read; the engine never drives a
// write and a read in the same cycle, which this block itself does not enforce.
// ----------------------------------------------------------------------------
module rlts_term_ring #(
   parameter int unsigned LOG_DEPTH = 1024,
   parameter int unsigned SLOT_W    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] addr,
   input  logic [63:0]       wr_data,
   output logic [63:0]       rd_data
);

   logic [63:0] mem [LOG_DEPTH];
   logic [63:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rlts_engine.sv @@
// ----------------------------------------------------------------------------
// rlts_engine
// Sequencer and index state: decodes one item, drives the ring access, and
// commits the new index state together with the result item.
// ----------------------------------------------------------------------------
module rlts_engine
   import rlts_pkg::*;
#(
   parameter int unsigned LOG_DEPTH = LOG_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    out_free,
   output logic    done_valid,
   output rsp_type done_data
);

   localparam int unsigned SLOT_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(LOG_DEPTH + 1);

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic [63:0]        first_ff, first_in;
   logic [63:0]        last_ff, last_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  base_slot_ff, base_slot_in;
   logic [63:0]        snap_index_ff, snap_index_in;
   logic [63:0]        snap_term_ff, snap_term_in;
   logic [63:0]        commit_ff, commit_in;
   logic [63:0]        hard_ff, hard_in;

   // decode results held for the finish cycle
   status_type         status_ff, status_in;
   tsrc_type           tsrc_ff, tsrc_in;
   logic               upd_ff, upd_in;
   logic [63:0]        rindex_ff, rindex_in;
   logic [CNT_W-1:0]   off_ff;

   logic               accept;
   logic               fire;
   logic [63:0]        idx;
   logic               held_idx;
   logic               held_cp;
   logic               lt_first;
   logic               gap;
   logic [63:0]        last_gap;
   logic [CNT_W-1:0]   diff_n;
   logic [63:0]        off_src;
   logic [SLOT_W-1:0]  off_n;
   logic [SLOT_W:0]    slot_sum;
   logic [SLOT_W-1:0]  ring_addr;
   logic               ring_wr;
   logic [63:0]        ring_rd;
   logic [SLOT_W:0]    base_sum;
   logic [63:0]        result_term;

   // handshake
   assign fire      = (state_ff == S_FINISH) && out_free;
   assign req_stall = !((state_ff == S_IDLE) || fire);
   assign accept    = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: state_in = S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = req_valid ? S_DECODE : S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign idx = req_ff.log_index;

   // index compares against the held window; an empty log keeps nothing
   assign lt_first = idx < first_ff;
   assign held_idx = (count_ff != '0) && !lt_first && (idx <= last_ff);
   assign held_cp  = (count_ff != '0) && (commit_ff >= first_ff) && (commit_ff <= last_ff);
   assign last_gap = idx - last_ff;
   assign gap      = (idx > last_ff) && (last_gap != 64'd1);
   assign diff_n   = (count_ff == '0) ? '0 : (idx[CNT_W-1:0] - first_ff[CNT_W-1:0]);

   // ring slot: offset from the first held entry, rotated by the base slot
   assign off_src  = (req_ff.operation == OP_SNAP_QUERY) ? commit_ff : idx;
   assign off_n    = (count_ff == '0) ? '0 : (off_src[SLOT_W-1:0] - first_ff[SLOT_W-1:0]);
   assign slot_sum = {1'b0, base_slot_ff} + {1'b0, off_n};
   always_comb begin
      if (slot_sum >= (SLOT_W+1)'(LOG_DEPTH)) begin
         ring_addr = SLOT_W'(slot_sum - (SLOT_W+1)'(LOG_DEPTH));
      end else begin
         ring_addr = slot_sum[SLOT_W-1:0];
      end
   end

   // decode
   always_comb begin
      status_in = ST_OK;
      tsrc_in   = TSRC_ZERO;
      upd_in    = 1'b0;
      rindex_in = '0;
      case (req_ff.operation)
         OP_APPEND: begin
            if (lt_first) begin
               status_in = ST_COMPACTED;
            end else if (gap) begin
               status_in = ST_GAP;
            end else if (diff_n == CNT_W'(LOG_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               upd_in = 1'b1;
            end
         end
         OP_COMPACT: begin
            if (idx <= first_ff) begin
               upd_in = 1'b0;
            end else if (gap) begin
               status_in = ST_BEYOND;
            end else begin
               upd_in = (count_ff != '0);
            end
         end
         OP_TERM_QUERY: begin
            if (idx == snap_index_ff) begin
               tsrc_in = TSRC_SNAP;
            end else if (held_idx) begin
               tsrc_in = TSRC_RING;
            end else if (lt_first) begin
               status_in = ST_COMPACTED;
            end else begin
               status_in = ST_UNAVAILABLE;
            end
         end
         OP_COMMIT_TO: begin
            if (held_idx) begin
               upd_in = 1'b1;
            end else begin
               status_in = ST_NO_ENTRY;
            end
         end
         OP_APPLY_SNAP: begin
            if (lt_first) begin
               status_in = ST_STALE;
            end else begin
               upd_in = 1'b1;
            end
         end
         OP_SNAP_QUERY: begin
            if (commit_ff == snap_index_ff) begin
               tsrc_in = TSRC_SNAP;
            end else if ((commit_ff > snap_index_ff) && held_cp) begin
               tsrc_in = TSRC_RING;
            end else begin
               status_in = ST_NO_ENTRY;
            end
            if (status_in == ST_OK) begin
               rindex_in = (commit_ff < idx) ? idx : commit_ff;
            end
         end
         default: begin
            upd_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DECODE) begin
         status_ff <= status_in;
         tsrc_ff   <= tsrc_in;
         upd_ff    <= upd_in;
         rindex_ff <= rindex_in;
         off_ff    <= diff_n;
      end
   end

   // ring access happens in the decode cycle, data returns for finish
   assign ring_wr = (state_ff == S_DECODE) && (req_ff.operation == OP_APPEND) && upd_in;

   rlts_term_ring #(
      .LOG_DEPTH (LOG_DEPTH),
      .SLOT_W    (SLOT_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .rd_en   ((state_ff == S_DECODE) && !ring_wr),
      .addr    (ring_addr),
      .wr_data (req_ff.entry_term),
      .rd_data (ring_rd)
   );

   // next index state at finish
   assign base_sum = {1'b0, base_slot_ff} + (SLOT_W+1)'(off_ff);
   always_comb begin
      first_in      = first_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      base_slot_in  = base_slot_ff;
      snap_index_in = snap_index_ff;
      snap_term_in  = snap_term_ff;
      commit_in     = commit_ff;
      hard_in       = hard_ff;
      if (fire && upd_ff) begin
         case (req_ff.operation)
            OP_APPEND: begin
               count_in = off_ff + CNT_W'(1);
               last_in  = idx;
               if (off_ff == '0) begin
                  first_in = idx;
               end
            end
            OP_COMPACT: begin
               count_in = count_ff - off_ff;
               if (base_sum >= (SLOT_W+1)'(LOG_DEPTH)) begin
                  base_slot_in = SLOT_W'(base_sum - (SLOT_W+1)'(LOG_DEPTH));
               end else begin
                  base_slot_in = base_sum[SLOT_W-1:0];
               end
               // an emptied log falls back to the snapshot
               if (count_ff == off_ff) begin
                  first_in = snap_index_ff + 64'd1;
                  last_in  = snap_index_ff;
               end else begin
                  first_in = idx;
               end
            end
            OP_COMMIT_TO: begin
               commit_in = idx;
               hard_in   = ring_rd;
            end
            OP_APPLY_SNAP: begin
               snap_index_in = idx;
               snap_term_in  = req_ff.entry_term;
               commit_in     = idx;
               count_in      = '0;
               first_in      = idx + 64'd1;
               last_in       = idx;
               if (req_ff.entry_term > hard_ff) begin
                  hard_in = req_ff.entry_term;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff      <= 64'd1;
         last_ff       <= '0;
         count_ff      <= '0;
         base_slot_ff  <= '0;
         snap_index_ff <= '0;
         snap_term_ff  <= '0;
         commit_ff     <= '0;
         hard_ff       <= '0;
      end else begin
         first_ff      <= first_in;
         last_ff       <= last_in;
         count_ff      <= count_in;
         base_slot_ff  <= base_slot_in;
         snap_index_ff <= snap_index_in;
         snap_term_ff  <= snap_term_in;
         commit_ff     <= commit_in;
         hard_ff       <= hard_in;
      end
   end

   // result item
   always_comb begin
      case (tsrc_ff)
         TSRC_SNAP: result_term = snap_term_ff;
         TSRC_RING: result_term = ring_rd;
         default:   result_term = '0;
      endcase
   end

   assign done_valid                  = (state_ff == S_FINISH);
   assign done_data.status            = status_ff;
   assign done_data.result_term       = result_term;
   assign done_data.result_index      = rindex_ff;
   assign done_data.first_entry_index = first_in;
   assign done_data.last_entry_index  = last_in;
   assign done_data.committed_index   = commit_in;
   assign done_data.hard_term         = hard_in;

endmodule
